// ===== rtl/core/rpip_pkg.sv =====
// Shared types and constants for the radix-prefixed integer parser.
// Used by every module of the block but rpip_checker; depends on nothing else.
`default_nettype none

package rpip_pkg;

	localparam int VALUE_BITS_DEF = 64;
	localparam int RADIX_BITS_DEF = 32;
	localparam int OUT_BITS       = 64;
	localparam int DIGIT_BITS     = 6;

	localparam int RADIX_BIN = 2;
	localparam int RADIX_OCT = 8;
	localparam int RADIX_DEC = 10;
	localparam int RADIX_HEX = 16;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DIG0  = 8'h30;
	localparam logic [7:0] CH_DIG9  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UB    = 8'h42;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	localparam logic [DIGIT_BITS-1:0] LETTER_BASE = 6'd10;

	typedef enum logic [2:0] {
		PH_START,
		PH_SIGN,
		PH_ZERO,
		PH_BASE,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic                  is_blank;
		logic                  is_minus;
		logic                  is_hash;
		logic                  is_zero;
		logic                  is_x;
		logic                  is_b;
		logic                  is_nul;
		logic                  is_dec;
		logic                  is_alnum;
		logic [DIGIT_BITS-1:0] digit;
	} char_class_t;

endpackage

`default_nettype wire

// ===== rtl/core/rpip_decode.sv =====
// Character classifier: flags the characters the parser reacts to and
// gives the digit value of 0-9, a-z and A-Z. Depends on rpip_pkg.
`default_nettype none

module rpip_decode import rpip_pkg::*; (
	input  wire logic [7:0]  ch,
	output char_class_t      cls
);

	logic is_dec, is_lower, is_upper;

	always_comb begin
		is_dec   = (ch >= CH_DIG0) && (ch <= CH_DIG9);
		is_lower = (ch >= CH_LA) && (ch <= CH_LZ);
		is_upper = (ch >= CH_UA) && (ch <= CH_UZ);

		cls.is_blank = (ch == CH_SPACE) || (ch == CH_TAB);
		cls.is_minus = (ch == CH_MINUS);
		cls.is_hash  = (ch == CH_HASH);
		cls.is_zero  = (ch == CH_DIG0);
		cls.is_x     = (ch == CH_LX) || (ch == CH_UX);
		cls.is_b     = (ch == CH_LB) || (ch == CH_UB);
		cls.is_nul   = (ch == CH_NUL);
		cls.is_dec   = is_dec;
		cls.is_alnum = is_dec || is_lower || is_upper;

		if (is_dec) begin
			cls.digit = DIGIT_BITS'(ch - CH_DIG0);
		end else if (is_lower) begin
			cls.digit = DIGIT_BITS'(ch - CH_LA) + LETTER_BASE;
		end else if (is_upper) begin
			cls.digit = DIGIT_BITS'(ch - CH_UA) + LETTER_BASE;
		end else begin
			cls.digit = '0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/rpip_mac.sv =====
// Multiply-accumulate acc * mul + add, wrapped to VALUE_BITS. The product
// is split into two half-width partial products. Depends on rpip_pkg.
`default_nettype none

module rpip_mac import rpip_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int RADIX_BITS = RADIX_BITS_DEF
) (
	input  wire logic [VALUE_BITS-1:0] acc,
	input  wire logic [RADIX_BITS-1:0] mul,
	input  wire logic [DIGIT_BITS-1:0] add,
	output logic      [VALUE_BITS-1:0] sum
);

	localparam int LO_BITS = (VALUE_BITS + 1) / 2;
	localparam int HI_BITS = VALUE_BITS - LO_BITS;

	logic [VALUE_BITS-1:0] a_lo, m_lo, p_lo;
	logic [HI_BITS-1:0]    m_hi, p_hi;

	always_comb begin
		// only the low bits of the upper partial product survive the wrap
		a_lo = VALUE_BITS'(acc[LO_BITS-1:0]);
		m_lo = VALUE_BITS'(mul);
		m_hi = HI_BITS'(mul);
		p_lo = a_lo * m_lo;
		p_hi = acc[VALUE_BITS-1:LO_BITS] * m_hi;
		sum  = p_lo + {p_hi, {LO_BITS{1'b0}}} + VALUE_BITS'(add);
	end

endmodule

`default_nettype wire

// ===== rtl/core/rpip_step.sv =====
// Next-state logic of the parser for one character: phase, sign, radix
// and accumulator. Depends on rpip_pkg and rpip_mac.
`default_nettype none

module rpip_step import rpip_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int RADIX_BITS = RADIX_BITS_DEF
) (
	input  wire phase_t                phase,
	input  wire logic                  negate,
	input  wire logic [RADIX_BITS-1:0] radix,
	input  wire logic [VALUE_BITS-1:0] accum,
	input  wire char_class_t           cls,
	output phase_t                     phase_nxt,
	output logic                       negate_nxt,
	output logic      [RADIX_BITS-1:0] radix_nxt,
	output logic      [VALUE_BITS-1:0] accum_nxt
);

	logic [RADIX_BITS-1:0] mul;
	logic [VALUE_BITS-1:0] mac_sum;
	logic                  take, digit_ok;

	// base digits fold in decimal; the digit after a bare zero is octal
	always_comb begin
		case (phase)
			PH_BASE: mul = RADIX_BITS'(RADIX_DEC);
			PH_ZERO: mul = RADIX_BITS'(RADIX_OCT);
			default: mul = radix;
		endcase
	end

	rpip_mac #(
		.VALUE_BITS(VALUE_BITS),
		.RADIX_BITS(RADIX_BITS)
	) u_mac (
		.acc(accum),
		.mul(mul),
		.add(cls.digit),
		.sum(mac_sum)
	);

	assign digit_ok = cls.is_alnum && (RADIX_BITS'(cls.digit) < mul);

	always_comb begin
		phase_nxt  = phase;
		negate_nxt = negate;
		radix_nxt  = radix;
		accum_nxt  = accum;
		take       = 1'b0;

		case (phase)
			PH_START, PH_SIGN: begin
				if (cls.is_blank && phase == PH_START) begin
					phase_nxt = PH_START;
				end else if (cls.is_minus) begin
					negate_nxt = ~negate;
					phase_nxt  = PH_SIGN;
				end else if (cls.is_zero) begin
					phase_nxt = PH_ZERO;
				end else if (cls.is_hash) begin
					phase_nxt = PH_BASE;
				end else begin
					take = 1'b1;
				end
			end
			PH_ZERO: begin
				if (cls.is_x) begin
					radix_nxt = RADIX_BITS'(RADIX_HEX);
					phase_nxt = PH_DIGITS;
				end else if (cls.is_b) begin
					radix_nxt = RADIX_BITS'(RADIX_BIN);
					phase_nxt = PH_DIGITS;
				end else begin
					radix_nxt = RADIX_BITS'(RADIX_OCT);
					take      = 1'b1;
				end
			end
			PH_BASE: begin
				if (cls.is_dec) begin
					accum_nxt = mac_sum;
				end else begin
					// drop the terminating character; a NUL ends the string
					radix_nxt = RADIX_BITS'(accum);
					accum_nxt = '0;
					phase_nxt = cls.is_nul ? PH_DONE : PH_DIGITS;
				end
			end
			PH_DIGITS: take = 1'b1;
			default:   phase_nxt = PH_DONE;
		endcase

		if (take) begin
			if (digit_ok) begin
				accum_nxt = mac_sum;
				phase_nxt = PH_DIGITS;
			end else begin
				phase_nxt = PH_DONE;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/radix_prefixed_integer_parser.sv =====
// Radix-prefixed integer parser, top level. Uses rpip_pkg, rpip_decode
// and rpip_step; holds the input register, parser state and result register.
`default_nettype none

// One character is taken per clock cycle while in_ready is high, and
// characters may follow each other in consecutive cycles without gaps. A
// character passes through an input register, is folded into the running
// value by one multiply-add (the rpip_mac unit) and lands in the parser
// state; the result of a last-marked item is registered onto out_valid and
// value. in_ready drops only while a result waits on the output and another
// last-marked character sits in the input register. The value is wrapped
// to VALUE_BITS and sign-extended to the 64-bit port. After each result
// the parser returns to its start state; no clearing pass is needed.
module radix_prefixed_integer_parser import rpip_pkg::*; #(
	parameter int VALUE_BITS = VALUE_BITS_DEF,
	parameter int RADIX_BITS = RADIX_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [7:0]          ch,
	input  wire logic                last,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [OUT_BITS-1:0] value
);

	logic                  valid_s1;
	logic [7:0]            ch_s1;
	logic                  last_s1;
	logic                  advance;

	phase_t                phase_q, phase_nxt;
	logic                  negate_q, negate_nxt;
	logic [RADIX_BITS-1:0] radix_q, radix_nxt;
	logic [VALUE_BITS-1:0] accum_q, accum_nxt;
	logic [VALUE_BITS-1:0] final_val;

	logic                  out_valid_q;
	logic [OUT_BITS-1:0]   value_q;

	char_class_t           cls;

	// a non-final character never waits on the output side
	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	rpip_decode u_decode (
		.ch(ch_s1),
		.cls(cls)
	);

	rpip_step #(
		.VALUE_BITS(VALUE_BITS),
		.RADIX_BITS(RADIX_BITS)
	) u_step (
		.phase(phase_q),
		.negate(negate_q),
		.radix(radix_q),
		.accum(accum_q),
		.cls(cls),
		.phase_nxt(phase_nxt),
		.negate_nxt(negate_nxt),
		.radix_nxt(radix_nxt),
		.accum_nxt(accum_nxt)
	);

	assign final_val = negate_nxt ? (VALUE_BITS'(0) - accum_nxt) : accum_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			phase_q     <= PH_START;
			negate_q    <= 1'b0;
			radix_q     <= RADIX_BITS'(RADIX_DEC);
			accum_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				if (last_s1) begin
					phase_q  <= PH_START;
					negate_q <= 1'b0;
					radix_q  <= RADIX_BITS'(RADIX_DEC);
					accum_q  <= '0;
				end else begin
					phase_q  <= phase_nxt;
					negate_q <= negate_nxt;
					radix_q  <= radix_nxt;
					accum_q  <= accum_nxt;
				end
			end
			if (advance && last_s1) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1   <= ch;
			last_s1 <= last;
		end
		if (advance && last_s1) begin
			value_q <= OUT_BITS'($signed(final_val));
		end
	end

	assign out_valid = out_valid_q;
	assign value     = $signed(value_q);

endmodule

`default_nettype wire

// ===== rtl/core/rpip_checker.sv =====
// Port-level checker for the radix-prefixed integer parser, bound to the
// top level. Sees only the top-level ports; no package dependency.
`default_nettype none

module rpip_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [7:0]  ch,
	input wire logic        last,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] value
);

	// a stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value))
		else $error("result changed while stalled");

	// input stalls only behind a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input stalled with output free");

	// an ending transaction is followed by out_valid once it has passed the input register
	a_last_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last |-> ##2 out_valid)
		else $error("no result after last transaction");

	// a new result only follows a cycle in which input was open
	a_rise_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_ready))
		else $error("result appeared after input stall");

endmodule

bind radix_prefixed_integer_parser rpip_checker u_rpip_checker (.*);

`default_nettype wire
